// ===== sv/alcm_pkg.sv =====
`timescale 1ns / 1ps

package alcm_pkg;

    // Widths of the transaction fields and of the configuration port.
    localparam int FIELD_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int BASE_W     = 13;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALIGNMENT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_ALIGNMENT = 1'b1;

    // Register values after reset.
    localparam logic [BASE_W-1:0]  BASE_RESET  = 13'd64;
    localparam logic [FIELD_W-1:0] LARGE_RESET = FIELD_W'(2 * 1024 * 1024);

    // Status that the lcm unit reports to its sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } lcm_stat_t;

endpackage

// ===== sv/alcm_req_if.sv =====
`timescale 1ns / 1ps

interface alcm_req_if import alcm_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] buffer_size;
    logic [FIELD_W-1:0] align_hint;

    modport source (output valid, output buffer_size, output align_hint, input ready);
    modport sink (input valid, input buffer_size, input align_hint, output ready);

endinterface

// ===== sv/alcm_rsp_if.sv =====
`timescale 1ns / 1ps

interface alcm_rsp_if import alcm_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] chosen_alignment;

    modport source (output valid, output chosen_alignment, input ready);
    modport sink (input valid, input chosen_alignment, output ready);

endinterface

// ===== sv/alcm_lcm_unit.sv =====
`timescale 1ns / 1ps

// Wrapped least common multiple: ((a * b) mod 2^DW) / gcd(a, b), or zero when
// both operands are zero. Binary gcd, scaling of the gcd by the common power of
// two (by shifts), shift-add multiply and restoring divide run in turn; all but
// the scaling go through one shared adder/subtractor.
module alcm_lcm_unit import alcm_pkg::*; #(
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output logic [DW-1:0] result,
    output lcm_stat_t     stat
);

    localparam int CW = $clog2(DW + 1);

    typedef enum logic [5:0] {
        U_IDLE  = 6'b000001,
        U_GCD   = 6'b000010,
        U_SCALE = 6'b000100,
        U_MUL   = 6'b001000,
        U_DIV   = 6'b010000,
        U_DONE  = 6'b100000
    } ustate_t;

    ustate_t       state_reg, state_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg, y_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [DW-1:0] p_reg, p_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [DW:0]   alu_a, alu_b;
    logic          alu_sub;
    logic [DW+1:0] alu_sum;
    logic          alu_ge;
    logic [DW:0]   div_shift;

    // Partial remainder shifted left by one with the next dividend bit.
    assign div_shift = {rem_reg, p_reg[DW-1]};

    // Operand selection for the shared adder.
    always_comb
    begin
        unique case (state_reg)
            U_MUL:
            begin
                alu_a   = {1'b0, p_reg};
                alu_b   = {1'b0, a_reg};
                alu_sub = 1'b0;
            end
            U_DIV:
            begin
                alu_a   = div_shift;
                alu_b   = {1'b0, x_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = {1'b0, x_reg};
                alu_b   = {1'b0, y_reg};
                alu_sub = 1'b1;
            end
        endcase
    end

    // The shared adder; in subtract mode the carry out means alu_a >= alu_b.
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (DW + 2)'(alu_sub);
    assign alu_ge  = alu_sum[DW+1];

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    x_next = op_a;
                    y_next = op_b;
                    a_next = op_a;
                    b_next = op_b;
                    k_next = '0;
                    if (op_a == '0 && op_b == '0)
                    begin
                        p_next     = '0;
                        state_next = U_DONE;
                    end
                    else
                    begin
                        state_next = U_GCD;
                    end
                end
            end
            U_GCD:
            begin
                priority if (x_reg == '0 || y_reg == '0)
                begin
                    x_next     = x_reg | y_reg;
                    state_next = U_SCALE;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (alu_ge)
                begin
                    // Difference of two odd values is even: halve it at once.
                    x_next = alu_sum[DW:1];
                end
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            U_SCALE:
            begin
                if (k_reg == '0)
                begin
                    p_next     = '0;
                    state_next = U_MUL;
                end
                else
                begin
                    x_next = x_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            U_MUL:
            begin
                if (b_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = U_DIV;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        p_next = alu_sum[DW-1:0];
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end
            U_DIV:
            begin
                if (alu_ge)
                begin
                    rem_next = alu_sum[DW-1:0];
                end
                else
                begin
                    rem_next = div_shift[DW-1:0];
                end
                p_next   = {p_reg[DW-2:0], alu_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
    end

    assign result    = p_reg;
    assign stat.busy = (state_reg != U_IDLE);
    assign stat.done = (state_reg == U_DONE);

    // The gcd loop never runs on two zero operands.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_GCD) |-> (x_reg != '0 || y_reg != '0))
        else $error("gcd loop entered with both operands zero");

    // The divisor is the nonzero gcd.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_DIV) |-> (x_reg != '0))
        else $error("division by a zero gcd");

    // The partial remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_DIV) |-> (rem_reg < x_reg))
        else $error("partial remainder not below divisor");

endmodule

// ===== sv/alignment_lcm_calculator_unit.sv =====
`timescale 1ns / 1ps

// Alignment chooser for buffer requests.
// The req channel carries buffer_size and align_hint (zero means no hint); the
// rsp channel returns chosen_alignment, one transaction per request. Both are
// valid/ready channels. The plain write port (cfg_we, cfg_index, cfg_wdata)
// sets base_alignment (index 0) and large_alignment (index 1); write it only
// while no request is in flight.
// A request needs zero, one or two lcm runs on a single shared adder inside
// alcm_lcm_unit. A run goes straight to its result when both operands are zero;
// otherwise it goes through the binary gcd steps, the gcd scaling, one multiply
// step per bit of the second operand and the restoring divide. The result is
// then registered and held on rsp in the T_OUT state.
// One request is processed at a time: req.ready is high only when idle, and
// the next request can be taken in the cycle after the result has been
// delivered. After reset the block is idle, base_alignment is 64 and
// large_alignment is 2 MiB. When the receiver stalls, the result holds on
// rsp and no new request is taken until it has been delivered.
module alignment_lcm_calculator_unit import alcm_pkg::*; #(
    parameter int POINTER_BYTES = 8,
    parameter int DATA_WIDTH    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    alcm_req_if.sink              req,
    alcm_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DW = DATA_WIDTH;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_MERGE = 4'b0010,
        T_FINAL = 4'b0100,
        T_OUT   = 4'b1000
    } tstate_t;

    tstate_t            state_reg, state_next;
    logic               start_reg, start_next;
    logic               ge_large_reg, ge_large_next;
    logic [DW-1:0]      op_a_reg, op_a_next;
    logic [DW-1:0]      op_b_reg, op_b_next;
    logic [FIELD_W-1:0] result_reg, result_next;
    logic [BASE_W-1:0]  base_reg;
    logic [FIELD_W-1:0] large_reg;

    logic               hint_nz;
    logic               ge_large;
    logic               ge_base;
    logic [DW-1:0]      lcm_result;
    lcm_stat_t          lcm_stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            large_reg <= LARGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_ALIGNMENT:  base_reg  <= cfg_wdata[BASE_W-1:0];
                CFG_LARGE_ALIGNMENT: large_reg <= cfg_wdata[FIELD_W-1:0];
                default:             base_reg  <= base_reg;
            endcase
        end
    end

    // Size class of the incoming request.
    assign hint_nz  = (req.align_hint != '0);
    assign ge_large = (req.buffer_size >= large_reg);
    assign ge_base  = (req.buffer_size >= FIELD_W'(base_reg));

    // Request sequencer.
    always_comb
    begin
        state_next    = state_reg;
        start_next    = 1'b0;
        ge_large_next = ge_large_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        result_next   = result_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (req.valid)
                begin
                    ge_large_next = ge_large;
                    priority if ((ge_large || ge_base) && hint_nz)
                    begin
                        op_a_next  = DW'(req.align_hint);
                        op_b_next  = DW'(base_reg);
                        start_next = 1'b1;
                        state_next = T_MERGE;
                    end
                    else if (ge_large)
                    begin
                        op_a_next  = DW'(base_reg);
                        op_b_next  = DW'(large_reg);
                        start_next = 1'b1;
                        state_next = T_FINAL;
                    end
                    else if (ge_base)
                    begin
                        result_next = FIELD_W'(base_reg);
                        state_next  = T_OUT;
                    end
                    else if (hint_nz)
                    begin
                        op_a_next  = DW'(req.align_hint);
                        op_b_next  = DW'(POINTER_BYTES);
                        start_next = 1'b1;
                        state_next = T_FINAL;
                    end
                    else
                    begin
                        result_next = FIELD_W'(POINTER_BYTES);
                        state_next  = T_OUT;
                    end
                end
            end
            T_MERGE:
            begin
                if (lcm_stat.done)
                begin
                    if (ge_large_reg)
                    begin
                        op_a_next  = lcm_result;
                        op_b_next  = DW'(large_reg);
                        start_next = 1'b1;
                        state_next = T_FINAL;
                    end
                    else
                    begin
                        result_next = FIELD_W'(lcm_result);
                        state_next  = T_OUT;
                    end
                end
            end
            T_FINAL:
            begin
                if (lcm_stat.done)
                begin
                    result_next = FIELD_W'(lcm_result);
                    state_next  = T_OUT;
                end
            end
            T_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    // Request payload and result.
    always_ff @(posedge clk)
    begin
        ge_large_reg <= ge_large_next;
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        result_reg   <= result_next;
    end

    alcm_lcm_unit #(
        .DW (DW)
    ) u_lcm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .op_a   (op_a_reg),
        .op_b   (op_b_reg),
        .result (lcm_result),
        .stat   (lcm_stat)
    );

    assign req.ready            = (state_reg == T_IDLE);
    assign rsp.valid            = (state_reg == T_OUT);
    assign rsp.chosen_alignment = result_reg;

    // A new lcm run is only launched on an idle unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !lcm_stat.busy)
        else $error("lcm run started while the unit is busy");

    // A finished lcm run is always awaited by the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        lcm_stat.done |-> (state_reg == T_MERGE || state_reg == T_FINAL))
        else $error("lcm result delivered with nobody waiting");

    // Requests are never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

endmodule
